// ===== design/boost_pid_duty_controller_assert.svh =====
// Assertion macros for the boost PID duty controller.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef BOOST_PID_DUTY_CONTROLLER_ASSERT_SVH
`define BOOST_PID_DUTY_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPDC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPDC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bpdc_pkg.sv =====
// Shared constants, types and register codes for the boost PID duty controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

  localparam int ADC_BITS       = 10;
  localparam int PWM_FULL_COUNT = 240;

  localparam int PWM_W      = 8;
  localparam int DUTY_W     = 16;
  localparam int TGT_W      = 8;
  localparam int MEAS_W     = 24;
  localparam int MEAS_OUT_W = 21;
  localparam int ERR_W      = 25;
  localparam int SCALE_W    = 16;
  localparam int GAIN_W     = 24;
  localparam int VLIM_W     = 8;

  // Shared multiplier: signed operand times an unsigned word taken 8 bits a cycle.
  localparam int OPND_W  = ERR_W + 1;
  localparam int DIGIT_W = 8;
  localparam int DCNT_W  = 2;
  localparam int ACC_W   = 52;

  localparam int LEAK_W       = 10;
  localparam int LEAK_SHIFT   = 16;
  localparam int TGT_SHIFT    = 15;
  localparam int VLIM_SHIFT   = 16;
  localparam int MEAS_DIGITS  = (SCALE_W + DIGIT_W - 1) / DIGIT_W;
  localparam int LEAK_DIGITS  = (LEAK_W + DIGIT_W - 1) / DIGIT_W;
  localparam int GAIN_DIGITS  = (GAIN_W + DIGIT_W - 1) / DIGIT_W;

  localparam logic [LEAK_W-1:0]       LEAK_Q16   = 10'd655;
  localparam logic [DUTY_W-1:0]       HALF_DUTY  = 16'd32768;
  localparam logic [DUTY_W-1:0]       DUTY_RESET = 16'd39322;
  localparam logic signed [TGT_W-1:0] TGT_RESET  = 8'sd20;
  localparam logic signed [TGT_W-1:0] TGT_MAX    = 8'sd127;
  localparam logic signed [TGT_W-1:0] TGT_MIN    = -8'sd128;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_UP   = 2'd1,
    FUNC_DOWN = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_SCALE = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_DUTY_LOW  = 3'd4,
    REG_DUTY_HIGH = 3'd5,
    REG_VOLT_LIM  = 3'd6,
    REG_FALLBACK  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SCALE_W-1:0]      adc_scale;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [DUTY_W-1:0]       duty_low;
    logic [DUTY_W-1:0]       duty_high;
    logic [VLIM_W-1:0]       volt_limit;
    logic signed [TGT_W-1:0] fallback_target;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              clr;
    logic [DCNT_W-1:0] ndig;
  } mac_cmd_t;

  typedef struct packed {
    logic [MEAS_OUT_W-1:0]   measured_q16;
    logic signed [TGT_W-1:0] target_half_volts;
    logic [DUTY_W-1:0]       duty_q16;
    logic [PWM_W-1:0]        pwm_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bpdc_digit_mac.sv =====
// Digit-serial multiply-accumulate unit: signed operand times an unsigned word,
// one 8-bit digit of the word per cycle. Depends on bpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_digit_mac (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bpdc_pkg::mac_cmd_t                 cmd,
  input  wire logic signed [bpdc_pkg::OPND_W-1:0] opnd_a,
  input  wire logic [bpdc_pkg::GAIN_W-1:0]        opnd_b,
  output logic                                    busy,
  output logic signed [bpdc_pkg::ACC_W-1:0]       acc
);
  import bpdc_pkg::*;

  localparam int PROD_W = OPND_W + DIGIT_W + 1;
  localparam int SH_W   = $clog2((GAIN_DIGITS - 1) * DIGIT_W + 1);

  logic signed [OPND_W-1:0]  a_reg;
  logic [GAIN_W-1:0]         b_sr;
  logic [DCNT_W-1:0]         cnt;
  logic [DCNT_W-1:0]         last;
  logic signed [DIGIT_W:0]   digit_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   addend;
  logic [SH_W-1:0]           sh;

  always_comb begin
    digit_s  = $signed({1'b0, b_sr[DIGIT_W-1:0]});
    prod     = a_reg * digit_s;
    prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    sh       = SH_W'(cnt) * SH_W'(DIGIT_W);
    addend   = prod_ext <<< sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.load) begin
      busy <= 1'b1;
    end else if (busy && (cnt == last)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg <= opnd_a;
      b_sr  <= opnd_b;
      cnt   <= '0;
      last  <= cmd.ndig - DCNT_W'(1);
      if (cmd.clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc  <= acc + addend;
      b_sr <= b_sr >> DIGIT_W;
      cnt  <= cnt + DCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/bpdc_core.sv =====
// Control sequencer and controller state: measurement, PID step and target steps.
// Depends on bpdc_pkg and bpdc_digit_mac.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpdc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic [bpdc_pkg::ADC_BITS-1:0] in_adc,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output bpdc_pkg::result_t                  res
);
  import bpdc_pkg::*;

  localparam int EW_W = ERR_W + 2;
  localparam int ND_W = ACC_W - GAIN_W + 1;
  localparam int PP_W = DUTY_W + PWM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAS,
    S_ERR,
    S_LEAK_LD,
    S_LEAK,
    S_PROP,
    S_INTEG,
    S_DERIV,
    S_DUTY,
    S_OUT
  } state_t;

  state_t                   state;
  logic [1:0]               func_q;
  logic [MEAS_W-1:0]        meas_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ERR_W-1:0]  integ;
  logic [DUTY_W-1:0]        duty;
  logic signed [TGT_W-1:0]  target;
  logic signed [ND_W-1:0]   nd_q;

  mac_cmd_t                 mac_cmd;
  logic signed [OPND_W-1:0] mac_a;
  logic [GAIN_W-1:0]        mac_b;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  acc;

  logic [MEAS_W-1:0]        meas_c;
  logic signed [EW_W-1:0]   tgt_scaled;
  logic signed [EW_W-1:0]   err_wide;
  logic signed [ACC_W-1:0]  leak_sh;
  logic signed [ACC_W-1:0]  corr_sh;
  logic signed [ND_W-1:0]   nd_c;
  logic signed [TGT_W-1:0]  target_next;
  logic [PP_W-1:0]          pwm_prod;
  logic                     duty_bad;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] x);
    logic signed [ERR_W-1:0] r;
    if (&x[ACC_W-1:ERR_W-1] || ~|x[ACC_W-1:ERR_W-1]) begin
      r = x[ERR_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(ERR_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(ERR_W - 1){1'b1}}};
    end
    return r;
  endfunction

  bpdc_digit_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .opnd_a (mac_a),
    .opnd_b (mac_b),
    .busy   (mac_busy),
    .acc    (acc)
  );

  // Arithmetic on the accumulator and the stored state.
  always_comb begin
    meas_c     = (|acc[ACC_W-1:MEAS_W]) ? {MEAS_W{1'b1}} : acc[MEAS_W-1:0];
    tgt_scaled = {{(EW_W - TGT_W - TGT_SHIFT){target[TGT_W-1]}}, target,
                  {TGT_SHIFT{1'b0}}};
    err_wide   = $signed(EW_W'(meas_q)) - tgt_scaled;
    leak_sh    = acc >>> LEAK_SHIFT;
    corr_sh    = acc >>> GAIN_W;
    nd_c       = $signed(ND_W'(duty)) - corr_sh[ND_W-1:0];
    duty_bad   = (nd_q > $signed(ND_W'(cfg.duty_high)))
              || (nd_q < $signed(ND_W'(cfg.duty_low)));
    pwm_prod   = PP_W'(duty) * PP_W'(PWM_FULL_COUNT);
  end

  // Target step: a refused request loads the fallback target.
  always_comb begin
    target_next = target;
    case (func_q)
      FUNC_UP: begin
        if (meas_c < {cfg.volt_limit, {VLIM_SHIFT{1'b0}}}) begin
          if (target != TGT_MAX) begin
            target_next = target + TGT_W'(1);
          end
        end else begin
          target_next = cfg.fallback_target;
        end
      end
      FUNC_DOWN: begin
        if (meas_c != '0) begin
          if (target != TGT_MIN) begin
            target_next = target - TGT_W'(1);
          end
        end else begin
          target_next = cfg.fallback_target;
        end
      end
      default: target_next = target;
    endcase
  end

  // Multiplier commands: P, I and D products sum into one accumulator.
  always_comb begin
    mac_cmd = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mac_cmd = '{load: 1'b1, clr: 1'b1, ndig: DCNT_W'(MEAS_DIGITS)};
          mac_a   = $signed(OPND_W'(in_adc));
          mac_b   = GAIN_W'(cfg.adc_scale);
        end
      end
      S_LEAK_LD: begin
        mac_cmd = '{load: 1'b1, clr: 1'b1, ndig: DCNT_W'(LEAK_DIGITS)};
        mac_a   = OPND_W'(err_q) + OPND_W'(integ);
        mac_b   = GAIN_W'(LEAK_Q16);
      end
      S_LEAK: begin
        if (!mac_busy) begin
          mac_cmd = '{load: 1'b1, clr: 1'b1, ndig: DCNT_W'(GAIN_DIGITS)};
          mac_a   = OPND_W'(err_q);
          mac_b   = cfg.gain_p;
        end
      end
      S_PROP: begin
        if (!mac_busy) begin
          mac_cmd = '{load: 1'b1, clr: 1'b0, ndig: DCNT_W'(GAIN_DIGITS)};
          mac_a   = OPND_W'(integ);
          mac_b   = cfg.gain_i;
        end
      end
      S_INTEG: begin
        if (!mac_busy) begin
          mac_cmd = '{load: 1'b1, clr: 1'b0, ndig: DCNT_W'(GAIN_DIGITS)};
          mac_a   = OPND_W'(err_q) - OPND_W'(prev_err);
          mac_b   = cfg.gain_d;
        end
      end
      default: mac_cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      duty     <= DUTY_RESET;
      prev_err <= '0;
      integ    <= '0;
      target   <= TGT_RESET;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= in_func;
            state  <= S_MEAS;
          end
        end
        S_MEAS: begin
          if (!mac_busy) begin
            meas_q <= meas_c;
            if (func_q == FUNC_TICK) begin
              state <= S_ERR;
            end else begin
              target <= target_next;
              state  <= S_OUT;
            end
          end
        end
        S_ERR: begin
          err_q <= sat_err(ACC_W'(err_wide));
          state <= S_LEAK_LD;
        end
        S_LEAK_LD: state <= S_LEAK;
        S_LEAK: begin
          if (!mac_busy) begin
            integ <= sat_err(leak_sh);
            state <= S_PROP;
          end
        end
        S_PROP: begin
          if (!mac_busy) begin
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (!mac_busy) begin
            prev_err <= err_q;
            state    <= S_DERIV;
          end
        end
        S_DERIV: begin
          if (!mac_busy) begin
            nd_q  <= nd_c;
            state <= S_DUTY;
          end
        end
        S_DUTY: begin
          duty  <= duty_bad ? HALF_DUTY : nd_q[DUTY_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_comb begin
    res.pwm_count         = pwm_prod[PP_W-1:DUTY_W];
    res.duty_q16          = duty;
    res.target_half_volts = target;
    res.measured_q16      = (|meas_q[MEAS_W-1:MEAS_OUT_W]) ? {MEAS_OUT_W{1'b1}}
                                                            : meas_q[MEAS_OUT_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/boost_pid_duty_controller.sv =====
// Boost converter PID duty controller. A control tick word runs the measurement and
// the full PID step; a target step or an unused function code runs only the
// measurement. The core takes no new word until the previous result has been handed
// to the output register. Most of the work goes through the single shared multiplier,
// which takes one 8-bit digit of its unsigned operand per cycle: two digits for the
// measurement, two for the integral leak and three for each of the three gains.
// The next word is taken while a finished result still waits in the output register.
// Holds the configuration registers, the stream ports and the output register;
// depends on bpdc_pkg, bpdc_core and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "boost_pid_duty_controller_assert.svh"

module boost_pid_duty_controller (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [9:0] adc_sample, [15:10] zero
  input  wire logic [bpdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  wire logic [bpdc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] pwm_count, [23:8] duty_q16, [31:24] target_half_volts,
  // [52:32] measured_q16, [55:53] zero
  output logic [bpdc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bpdc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bpdc_pkg::*;

  localparam int RES_W = $bits(result_t);

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_scale       <= 16'd1201;
      cfg.gain_p          <= 24'd33554;
      cfg.gain_i          <= 24'd335544;
      cfg.gain_d          <= 24'd167772;
      cfg.duty_low        <= 16'd6554;
      cfg.duty_high       <= 16'd62259;
      cfg.volt_limit      <= 8'd15;
      cfg.fallback_target <= 8'sd10;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ADC_SCALE: cfg.adc_scale       <= cfg_wdata[SCALE_W-1:0];
        REG_GAIN_P:    cfg.gain_p          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg.gain_i          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg.gain_d          <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_LOW:  cfg.duty_low        <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_HIGH: cfg.duty_high       <= cfg_wdata[DUTY_W-1:0];
        REG_VOLT_LIM:  cfg.volt_limit      <= cfg_wdata[VLIM_W-1:0];
        REG_FALLBACK:  cfg.fallback_target <= $signed(cfg_wdata[TGT_W-1:0]);
        default:       cfg.adc_scale       <= cfg.adc_scale;
      endcase
    end
  end

  bpdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser[1:0]),
    .in_adc    (s_axis_tdata[ADC_BITS-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: refilled in the same cycle the waiting word is taken.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

  `BPDC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "core took a new word while still working on the previous one")
  `BPDC_ASSERT_NXT(a_result_lands, res_valid && res_ready, m_axis_tvalid, "result handed over by the core did not reach the output register")
  `BPDC_ASSERT_IMP(a_pwm_range, m_axis_tvalid, out_res.pwm_count < PWM_W'(PWM_FULL_COUNT), "pwm count reached the full count")

endmodule

`default_nettype wire
